[rtl/core/apcp_pkg.sv]
// Package for the ASCII pulse command parser: widths, character codes,
// token state type and the width clamp function. No dependencies.
`default_nettype none

package apcp_pkg;

    localparam int CHANNELS   = 4;
    localparam int OUT_FIELDS = 4;
    localparam int CNT_W      = $clog2(CHANNELS + 1);
    localparam int MAG_W      = 12;
    localparam int PULSE_W    = 11;

    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;
    localparam logic [MAG_W-1:0]   MAG_MAX   = 12'd4095;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             minus;
        logic             nonempty;
        phase_t           phase;
    } token_t;

    localparam token_t TOKEN_CLEAR = '{mag: '0, minus: 1'b0, nonempty: 1'b0, phase: PH_LEAD};

    function automatic logic [PULSE_W-1:0] clamp_width(input token_t tok);
        logic [PULSE_W-1:0] w;
        if (tok.minus || tok.mag < MAG_W'(PULSE_MIN)) begin
            w = PULSE_MIN;
        end else if (tok.mag > MAG_W'(PULSE_MAX)) begin
            w = PULSE_MAX;
        end else begin
            w = tok.mag[PULSE_W-1:0];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/apcp_char_step.sv]
// Token update for one non-space character: whitespace skip, sign, digit
// accumulate with saturation. Depends on apcp_pkg.
`default_nettype none

module apcp_char_step (
    input  wire  logic [7:0]      ascii_char,
    input  wire  apcp_pkg::token_t tok,
    output apcp_pkg::token_t      tok_next
);
    import apcp_pkg::*;

    logic             is_ws;
    logic             is_sign;
    logic             is_digit;
    logic [MAG_W+3:0] mag_wide;

    always_comb
    begin
        is_ws    = (ascii_char >= CHAR_TAB) && (ascii_char <= CHAR_CR);
        is_sign  = (ascii_char == CHAR_PLUS) || (ascii_char == CHAR_MINUS);
        is_digit = (ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_NINE);
        // mag * 10 = (mag << 3) + (mag << 1)
        mag_wide = ({4'b0, tok.mag} << 3) + ({4'b0, tok.mag} << 1)
                 + (MAG_W+4)'(ascii_char - CHAR_ZERO);

        tok_next          = tok;
        tok_next.nonempty = 1'b1;
        if (tok.phase == PH_LEAD && is_ws) begin
            tok_next.phase = PH_LEAD;
        end else if (tok.phase == PH_LEAD && is_sign) begin
            tok_next.minus = (ascii_char == CHAR_MINUS);
            tok_next.phase = PH_NUM;
        end else if (tok.phase != PH_DONE && is_digit) begin
            tok_next.mag   = (mag_wide > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX
                                                              : mag_wide[MAG_W-1:0];
            tok_next.phase = PH_NUM;
        end else begin
            tok_next.phase = PH_DONE;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ascii_pulse_command_parser_unit.sv]
// Top level of the ASCII pulse command parser: input register, token and
// slot state, result register. Depends on apcp_pkg and apcp_char_step.
`default_nettype none

// Takes one command character per cycle. A request is registered in the
// stage register, its token/slot update is done from there, and on the
// character flagged is_last the four clamped pulse widths land in the
// result register. The input side keeps taking one character a cycle
// while a result waits; it stalls only when a second last character
// reaches the update stage while the previous result has not been taken.
// No clearing pass after reset.
module ascii_pulse_command_parser_unit (
    input  wire  logic                         clk,
    input  wire  logic                         rst_n,
    input  wire  logic                         in_valid,
    output logic                               in_ready,
    input  wire  logic [7:0]                   ascii_char,
    input  wire  logic                         is_last,
    output logic                               out_valid,
    input  wire  logic                         out_ready,
    output logic [apcp_pkg::PULSE_W-1:0]       pulse_a,
    output logic [apcp_pkg::PULSE_W-1:0]       pulse_b,
    output logic [apcp_pkg::PULSE_W-1:0]       pulse_c,
    output logic [apcp_pkg::PULSE_W-1:0]       pulse_d
);
    import apcp_pkg::*;

    logic               stage_valid_reg;
    logic [7:0]         stage_char_reg;
    logic               stage_last_reg;
    logic               advance;

    token_t             tok_reg, tok_next, tok_take, close_tok;
    logic [CNT_W-1:0]   slot_count_reg, slot_count_next;
    logic [PULSE_W-1:0] slot_reg [CHANNELS];
    logic [PULSE_W-1:0] slot_next [CHANNELS];
    logic [PULSE_W-1:0] res_next [OUT_FIELDS];
    logic               closing, store;

    logic               out_valid_reg;
    logic [PULSE_W-1:0] res_reg [OUT_FIELDS];

    apcp_char_step u_step (
        .ascii_char (stage_char_reg),
        .tok        (tok_reg),
        .tok_next   (tok_take)
    );

    // a last item waits here only while the result register is occupied and not being taken
    assign advance  = stage_valid_reg && (!stage_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else if (in_ready) begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            stage_char_reg <= ascii_char;
            stage_last_reg <= is_last;
        end
    end

    always_comb
    begin
        closing   = (stage_char_reg == CHAR_SPACE) || stage_last_reg;
        // a space closes the token as it stood; a last non-space first joins it
        close_tok = (stage_char_reg == CHAR_SPACE) ? tok_reg : tok_take;
        store     = closing && close_tok.nonempty && (slot_count_reg < CNT_W'(CHANNELS));

        slot_count_next = store ? slot_count_reg + CNT_W'(1) : slot_count_reg;
        tok_next        = closing ? TOKEN_CLEAR : tok_take;
        for (int i = 0; i < CHANNELS; i++) begin
            slot_next[i] = (store && slot_count_reg == CNT_W'(i)) ? clamp_width(close_tok)
                                                                 : slot_reg[i];
        end
        for (int j = 0; j < OUT_FIELDS; j++) begin
            res_next[j] = PULSE_MIN;
            if (j < CHANNELS) begin
                res_next[j] = slot_next[(j < CHANNELS) ? j : 0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_reg        <= TOKEN_CLEAR;
            slot_count_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                slot_reg[i] <= PULSE_MIN;
            end
        end else if (advance) begin
            if (stage_last_reg) begin
                tok_reg        <= TOKEN_CLEAR;
                slot_count_reg <= '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    slot_reg[i] <= PULSE_MIN;
                end
            end else begin
                tok_reg        <= tok_next;
                slot_count_reg <= slot_count_next;
                for (int i = 0; i < CHANNELS; i++) begin
                    slot_reg[i] <= slot_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && stage_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_last_reg) begin
            for (int j = 0; j < OUT_FIELDS; j++) begin
                res_reg[j] <= res_next[j];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pulse_a   = res_reg[0];
    assign pulse_b   = res_reg[1];
    assign pulse_c   = res_reg[2];
    assign pulse_d   = res_reg[3];

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_last_reg) |=> out_valid_reg)
        else $error("last character did not load a result");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_last_reg) |=> (slot_count_reg == '0 && !tok_reg.nonempty))
        else $error("state not cleared after command end");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pulse_a >= PULSE_MIN && pulse_a <= PULSE_MAX
                        && pulse_d >= PULSE_MIN && pulse_d <= PULSE_MAX))
        else $error("pulse width out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_count_reg <= CNT_W'(CHANNELS))
        else $error("slot count beyond channel count");

    a_stage_free: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_last_reg) |-> in_ready)
        else $error("input stalled on a non-last character");

endmodule

`default_nettype wire

[test/tb_ascii_pulse_command_parser_unit.sv]
// Testbench for ascii_pulse_command_parser_unit: sends command characters,
// predicts the four pulse widths per command and checks every result.
// Depends on apcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ascii_pulse_command_parser_unit;
    import apcp_pkg::*;

    localparam int LIMIT = 300000;

    typedef struct packed {
        logic [PULSE_W-1:0] a;
        logic [PULSE_W-1:0] b;
        logic [PULSE_W-1:0] c;
        logic [PULSE_W-1:0] d;
    } width_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] ascii_char = 8'h00;
    logic is_last = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [PULSE_W-1:0] pulse_a;
    logic [PULSE_W-1:0] pulse_b;
    logic [PULSE_W-1:0] pulse_c;
    logic [PULSE_W-1:0] pulse_d;

    // parser state mirror
    logic [MAG_W-1:0] tok_mag;
    logic tok_minus;
    logic tok_filled;
    phase_t tok_phase;
    int slot_cnt;
    logic [PULSE_W-1:0] slot_w [OUT_FIELDS];

    width_set_t pending_widths[$];
    logic [7:0] cmd_buf[$];
    int err_count = 0;
    int chars_sent = 0;
    int cycle_cnt = 0;
    int rx_hold = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    ascii_pulse_command_parser_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .ascii_char(ascii_char),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pulse_a(pulse_a),
        .pulse_b(pulse_b),
        .pulse_c(pulse_c),
        .pulse_d(pulse_d)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_command();
        tok_mag = '0;
        tok_minus = 1'b0;
        tok_filled = 1'b0;
        tok_phase = PH_LEAD;
        slot_cnt = 0;
        for (int j = 0; j < OUT_FIELDS; j++)
        begin
            slot_w[j] = PULSE_MIN;
        end
    endfunction

    function automatic void store_token();
        logic [PULSE_W-1:0] w;
        if (tok_filled && slot_cnt < CHANNELS)
        begin
            if (tok_minus || tok_mag < MAG_W'(PULSE_MIN))
                w = PULSE_MIN;
            else if (tok_mag > MAG_W'(PULSE_MAX))
                w = PULSE_MAX;
            else
                w = tok_mag[PULSE_W-1:0];
            slot_w[slot_cnt] = w;
            slot_cnt++;
        end
        tok_mag = '0;
        tok_minus = 1'b0;
        tok_filled = 1'b0;
        tok_phase = PH_LEAD;
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        int m;
        tok_filled = 1'b1;
        if (tok_phase == PH_LEAD && c >= CHAR_TAB && c <= CHAR_CR)
        begin
            // leading whitespace is skipped but still makes the token count
        end
        else if (tok_phase == PH_LEAD && (c == CHAR_PLUS || c == CHAR_MINUS))
        begin
            tok_minus = (c == CHAR_MINUS);
            tok_phase = PH_NUM;
        end
        else if (tok_phase != PH_DONE && c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            m = int'(tok_mag) * 10 + int'(c) - int'(CHAR_ZERO);
            tok_mag = (m > int'(MAG_MAX)) ? MAG_MAX : MAG_W'(m);
            tok_phase = PH_NUM;
        end
        else
        begin
            tok_phase = PH_DONE;
        end
    endfunction

    function automatic void predict_widths(input logic [7:0] c, input logic last);
        width_set_t ws;
        if (c == CHAR_SPACE)
            store_token();
        else
            absorb_char(c);
        if (last)
        begin
            store_token();
            ws.a = slot_w[0];
            ws.b = slot_w[1];
            ws.c = slot_w[2];
            ws.d = slot_w[3];
            pending_widths.push_back(ws);
            clear_command();
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        width_set_t ws;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_widths.size() == 0)
            begin
                report_mismatch("result with no command pending, pulse_a", int'(pulse_a), 0);
            end
            else
            begin
                ws = pending_widths.pop_front();
                if (pulse_a !== ws.a) report_mismatch("pulse_a", int'(pulse_a), int'(ws.a));
                if (pulse_b !== ws.b) report_mismatch("pulse_b", int'(pulse_b), int'(ws.b));
                if (pulse_c !== ws.c) report_mismatch("pulse_c", int'(pulse_c), int'(ws.c));
                if (pulse_d !== ws.d) report_mismatch("pulse_d", int'(pulse_d), int'(ws.d));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT)
        begin
            $display("tb_ascii_pulse_command_parser_unit: errors");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        int gap;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            else
            begin
                gap = rx_calm ? 0 : $urandom_range(0, 13);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid && rx_hold == 0) @(posedge clk);
        end
    end

    // Leaves valid high after the request is taken; the next call or
    // wait_drained decides what valid does in that step.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ascii_char <= c;
        is_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_widths(c, last);
        chars_sent++;
    endtask

    task automatic send_cmd_buf();
        for (int i = 0; i < cmd_buf.size(); i++)
        begin
            send_char(cmd_buf[i], i == cmd_buf.size() - 1);
        end
        cmd_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            cmd_buf.push_back(s[i]);
        end
        send_cmd_buf();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_widths.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic add_token();
        int v;
        string s;
        if ($urandom_range(0, 5) == 0)
            cmd_buf.push_back(8'($urandom_range(int'(CHAR_TAB), int'(CHAR_CR))));
        case ($urandom_range(0, 5))
            0: cmd_buf.push_back(CHAR_PLUS);
            1: cmd_buf.push_back(CHAR_MINUS);
            default: ;
        endcase
        // now and then no digits at all, so a sign may stand alone
        if ($urandom_range(0, 11) != 0)
        begin
            case ($urandom_range(0, 7))
                0: v = $urandom_range(0, 99999);
                1: v = $urandom_range(0, 999);
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 999;
                        1: v = 1000;
                        2: v = 2000;
                        default: v = 2001;
                    endcase
                end
                default: v = $urandom_range(950, 2050);
            endcase
            if ($urandom_range(0, 9) == 0)
                cmd_buf.push_back(CHAR_ZERO);
            s = $sformatf("%0d", v);
            for (int k = 0; k < s.len(); k++)
            begin
                cmd_buf.push_back(s[k]);
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            v = $urandom_range(0, 255);
            cmd_buf.push_back((8'(v) == CHAR_SPACE) ? 8'h7A : 8'(v));
        end
    endtask

    task automatic build_command();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0)
            cmd_buf.push_back(CHAR_SPACE);
        for (int t = 0; t < n; t++)
        begin
            add_token();
            if (t < n - 1)
            begin
                cmd_buf.push_back(CHAR_SPACE);
                if ($urandom_range(0, 5) == 0)
                    cmd_buf.push_back(CHAR_SPACE);
            end
        end
        if ($urandom_range(0, 7) == 0)
            cmd_buf.push_back(CHAR_SPACE);
    endtask

    task automatic test_basic_width();
        send_text("1500");
        wait_drained();
    endtask

    // leading tab with minus, saturating run, bare sign, stray letter,
    // a fifth token that is dropped, and a space as last character
    task automatic test_token_rules();
        send_text("\t-5 99999 + 2a9 7 ");
        wait_drained();
    endtask

    task automatic test_single_byte_commands();
        send_char(8'hFF, 1'b1);
        send_char(CHAR_SPACE, 1'b1);
        send_char(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_wellformed_commands();
        while (chars_sent < 720)
        begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            build_command();
            send_cmd_buf();
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();
    endtask

    // results back up behind a long hold-off until the input stalls
    task automatic test_input_stall();
        int n;
        rx_hold = 300;
        tx_calm = 1'b1;
        for (int k = 0; k < 20; k++)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                cmd_buf.push_back(8'($urandom_range(int'(CHAR_ZERO), int'(CHAR_NINE))));
            end
            send_cmd_buf();
        end
        tx_calm = 1'b0;
        wait_drained();
    endtask

    task automatic test_byte_noise();
        logic [7:0] c;
        for (int i = 0; i < 170; i++)
        begin
            case ($urandom_range(0, 3))
                0: c = CHAR_SPACE;
                1: c = 8'($urandom_range(int'(CHAR_ZERO), int'(CHAR_NINE)));
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_char(c, ($urandom_range(0, 11) == 0) || (i == 169));
        end
        wait_drained();
    endtask

    initial
    begin
        clear_command();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_width();
        test_token_rules();
        test_single_byte_commands();
        test_wellformed_commands();
        test_input_stall();
        test_byte_noise();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb_ascii_pulse_command_parser_unit: clean");
        else
            $display("tb_ascii_pulse_command_parser_unit: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/apcp_pkg.sv
rtl/core/apcp_char_step.sv
rtl/core/ascii_pulse_command_parser_unit.sv
test/tb_ascii_pulse_command_parser_unit.sv
